// ===== design/eatrm_pkg.sv =====
package eatrm_pkg;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } out_beat_t;

    // sine/cosine pair for one angle, Q1.14
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sc_t;

    // pipeline stage count: 9 sine/cosine stages plus 3 matrix stages
    localparam int NumCells = 12;

    localparam logic [31:0] One29  = 32'd536870912;
    localparam logic signed [35:0] HalfPi = 36'sd843314857;
    localparam logic signed [35:0] QPi    = 36'sd421657428;
    localparam logic [31:0] C6     = 32'd89478485;
    localparam logic [31:0] C120   = 32'd4473924;
    localparam logic [31:0] C5040  = 32'd106522;
    localparam logic [31:0] C2     = 32'd268435456;
    localparam logic [31:0] C24    = 32'd22369621;
    localparam logic [31:0] C720   = 32'd745654;
    localparam logic [31:0] C40320 = 32'd13315;

    // rounded Q.29 product of two values below 2^30
    function automatic logic [31:0] mul29(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'd268435456;
        return p[60:29];
    endfunction

    // round magnitude half away from zero by 15
    function automatic logic signed [15:0] rnd15(input logic signed [33:0] v);
        logic [33:0] m;
        logic [33:0] r;
        m = v[33] ? 34'(-v) : 34'(v);
        r = (m + 34'd16384) >> 15;
        return v[33] ? -16'(r) : 16'(r);
    endfunction

endpackage

// ===== design/eatrm_sincos.sv =====
// Sine/cosine of one angle over a chain of stages: reduction, Horner steps.
module eatrm_sincos (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output eatrm_pkg::sc_t     sc
);
    // stage 0: reduce angle; q by compare over eight quadrant bounds
    logic signed [35:0] x;
    logic signed [35:0] r0;
    logic [2:0]         q0;
    always_comb begin
        x  = 36'(angle) <<< 16;
        q0 = 3'd0;
        r0 = x + 36'sd4 * eatrm_pkg::HalfPi;
        for (int i = 0; i < 8; i++) begin
            if (x + eatrm_pkg::QPi + 36'sd4 * eatrm_pkg::HalfPi
                    >= 36'(i + 1) * eatrm_pkg::HalfPi) begin
                q0 = 3'(i + 1 - 4);
                r0 = x - 36'(i + 1 - 4) * eatrm_pkg::HalfPi;
            end
        end
    end

    logic [31:0] u_reg [1:6];
    logic [31:0] u2_reg [2:6];
    logic [31:0] ps_reg [3:8];
    logic [31:0] pc_reg [3:8];
    logic [1:0]  q_reg [1:8];
    logic        n_reg [1:8];
    eatrm_pkg::sc_t sc_reg;
    eatrm_pkg::sc_t sc_next;
    logic signed [33:0] s, c;

    // advance the Horner steps through the stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[1] <= r0[35] ? 32'(-r0) : 32'(r0);
            n_reg[1] <= r0[35];
            q_reg[1] <= q0[1:0];
            for (int k = 2; k <= 6; k++) u_reg[k] <= u_reg[k-1];
            for (int k = 2; k <= 8; k++) begin
                n_reg[k] <= n_reg[k-1];
                q_reg[k] <= q_reg[k-1];
            end
            u2_reg[2] <= eatrm_pkg::mul29(u_reg[1], u_reg[1]);
            for (int k = 3; k <= 6; k++) u2_reg[k] <= u2_reg[k-1];
            ps_reg[3] <= eatrm_pkg::C120 - eatrm_pkg::mul29(u2_reg[2], eatrm_pkg::C5040);
            pc_reg[3] <= eatrm_pkg::C720 - eatrm_pkg::mul29(u2_reg[2], eatrm_pkg::C40320);
            ps_reg[4] <= ps_reg[3];
            pc_reg[4] <= pc_reg[3];
            ps_reg[5] <= eatrm_pkg::C6 - eatrm_pkg::mul29(u2_reg[4], ps_reg[4]);
            pc_reg[5] <= eatrm_pkg::C24 - eatrm_pkg::mul29(u2_reg[4], pc_reg[4]);
            ps_reg[6] <= eatrm_pkg::One29 - eatrm_pkg::mul29(u2_reg[5], ps_reg[5]);
            pc_reg[6] <= eatrm_pkg::C2 - eatrm_pkg::mul29(u2_reg[5], pc_reg[5]);
            ps_reg[7] <= eatrm_pkg::mul29(u_reg[6], ps_reg[6]);
            pc_reg[7] <= eatrm_pkg::One29 - eatrm_pkg::mul29(u2_reg[6], pc_reg[6]);
            ps_reg[8] <= ps_reg[7];
            pc_reg[8] <= pc_reg[7];
            sc_reg    <= sc_next;
        end
    end

    // restore sign and pick quadrant
    always_comb begin
        s = n_reg[8] ? -34'(ps_reg[8]) : 34'(ps_reg[8]);
        c = 34'(pc_reg[8]);
        case (q_reg[8])
            2'd0: sc_next = '{eatrm_pkg::rnd15(s), eatrm_pkg::rnd15(c)};
            2'd1: sc_next = '{eatrm_pkg::rnd15(c), eatrm_pkg::rnd15(-s)};
            2'd2: sc_next = '{eatrm_pkg::rnd15(-s), eatrm_pkg::rnd15(-c)};
            default: sc_next = '{eatrm_pkg::rnd15(-c), eatrm_pkg::rnd15(s)};
        endcase
    end
    assign sc = sc_reg;
endmodule

// ===== design/eatrm_matrix.sv =====
// Matrix elements in three stages: products, triple products, round/saturate.
module eatrm_matrix (
    input  logic                 aclk,
    input  logic                 en,
    input  eatrm_pkg::sc_t       x,
    input  eatrm_pkg::sc_t       y,
    input  eatrm_pkg::sc_t       z,
    output eatrm_pkg::out_beat_t res
);
    logic signed [31:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    logic signed [31:0] cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg;
    logic signed [15:0] sy_reg, sz_reg, cz_reg;
    logic signed [47:0] e_reg [9];
    eatrm_pkg::out_beat_t res_reg;

    function automatic logic signed [15:0] elem(input logic signed [47:0] v);
        logic [47:0] m;
        logic [47:0] r;
        m = v[47] ? 48'(-v) : 48'(v);
        r = (m + 48'd134217728) >> 28;
        if (r > 48'd16384) r = 48'd16384;
        return v[47] ? -16'(r) : 16'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            sxsy_reg <= x.s * y.s;  cxsy_reg <= x.c * y.s;
            cycz_reg <= y.c * z.c;  cysz_reg <= y.c * z.s;
            sxcy_reg <= x.s * y.c;  cxcy_reg <= x.c * y.c;
            cxsz_reg <= x.c * z.s;  cxcz_reg <= x.c * z.c;
            sxsz_reg <= x.s * z.s;  sxcz_reg <= x.s * z.c;
            sy_reg <= y.s; sz_reg <= z.s; cz_reg <= z.c;
            e_reg[0] <= 48'(cycz_reg) <<< 14;
            e_reg[1] <= -(48'(cysz_reg) <<< 14);
            e_reg[2] <= 48'(sy_reg) <<< 28;
            e_reg[3] <= 48'(sxsy_reg) * 48'(cz_reg) + (48'(cxsz_reg) <<< 14);
            e_reg[4] <= (48'(cxcz_reg) <<< 14) - 48'(sxsy_reg) * 48'(sz_reg);
            e_reg[5] <= -(48'(sxcy_reg) <<< 14);
            e_reg[6] <= (48'(sxsz_reg) <<< 14) - 48'(cxsy_reg) * 48'(cz_reg);
            e_reg[7] <= 48'(cxsy_reg) * 48'(sz_reg) + (48'(sxcz_reg) <<< 14);
            e_reg[8] <= 48'(cxcy_reg) <<< 14;
            res_reg <= '{elem(e_reg[0]), elem(e_reg[1]), elem(e_reg[2]),
                         elem(e_reg[3]), elem(e_reg[4]), elem(e_reg[5]),
                         elem(e_reg[6]), elem(e_reg[7]), elem(e_reg[8])};
        end
    end
    assign res = res_reg;
endmodule

// ===== design/euler_angles_to_rotation_matrix_core.sv =====
// Throughput: one beat per cycle; the 12-stage chain (9 sine/cosine
// stages, 3 matrix stages) advances whenever the output side is free.
// Reset: aresetn synchronous active low clears the stage valid bits only.
module euler_angles_to_rotation_matrix_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  eatrm_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output eatrm_pkg::out_beat_t m_data
);
    logic [eatrm_pkg::NumCells-1:0] vld_reg;
    logic           en;
    eatrm_pkg::sc_t scx, scy, scz;

    // stall the whole chain only when the last beat is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[eatrm_pkg::NumCells-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en)  vld_reg <= {vld_reg[eatrm_pkg::NumCells-2:0], s_valid};
    end

    eatrm_sincos u_x (.aclk, .en, .angle(s_data.roll_angle),  .sc(scx));
    eatrm_sincos u_y (.aclk, .en, .angle(s_data.pitch_angle), .sc(scy));
    eatrm_sincos u_z (.aclk, .en, .angle(s_data.yaw_angle),   .sc(scz));
    eatrm_matrix u_m (.aclk, .en, .x(scx), .y(scy), .z(scz), .res(m_data));
endmodule

// ===== tb/euler_angles_to_rotation_matrix_checker.sv =====
module euler_angles_to_rotation_matrix_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  eatrm_pkg::in_beat_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  eatrm_pkg::out_beat_t m_data,
    output int                   fail_count,
    output int                   pending_count
);
    localparam longint unsigned Q29One   = 64'd536870912;
    localparam longint          Q29HalfPi = 64'sd843314857;
    localparam longint          Q29QPi    = 64'sd421657428;
    localparam longint unsigned K6     = 64'd89478485;
    localparam longint unsigned K120   = 64'd4473924;
    localparam longint unsigned K5040  = 64'd106522;
    localparam longint unsigned K2     = 64'd268435456;
    localparam longint unsigned K24    = 64'd22369621;
    localparam longint unsigned K720   = 64'd745654;
    localparam longint unsigned K40320 = 64'd13315;

    eatrm_pkg::out_beat_t matrix_queue[$];
    int        mismatch_count;

    function automatic longint unsigned q29_mult(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 28)) >> 29;
    endfunction

    function automatic longint round_away(longint v, int sh, bit sat);
        longint unsigned mag;
        longint unsigned m;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        m = (mag + (64'd1 << (sh - 1))) >> sh;
        if (sat && m > 64'd16384) m = 64'd16384;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void angle_sincos(input logic signed [15:0] ang, output longint sn,
                                         output longint cs);
        longint x, q, r, s, c, so, co;
        longint unsigned u, u2, p;
        x = longint'(ang) * 65536;
        q = (x + Q29QPi + 4 * Q29HalfPi) / Q29HalfPi - 4;
        r = x - q * Q29HalfPi;
        u = (r < 0) ? longint'(-r) : longint'(r);
        u2 = q29_mult(u, u);
        p = K120 - q29_mult(u2, K5040);
        p = K6 - q29_mult(u2, p);
        p = Q29One - q29_mult(u2, p);
        s = longint'(q29_mult(u, p));
        if (r < 0) s = -s;
        p = K720 - q29_mult(u2, K40320);
        p = K24 - q29_mult(u2, p);
        p = K2 - q29_mult(u2, p);
        c = longint'(Q29One - q29_mult(u2, p));
        case ((q + 4) & 3)
            0: begin so = s;  co = c;  end
            1: begin so = c;  co = -s; end
            2: begin so = -s; co = -c; end
            default: begin so = -c; co = s; end
        endcase
        sn = round_away(so, 15, 1'b0);
        cs = round_away(co, 15, 1'b0);
    endfunction

    function automatic logic signed [15:0] q42_elem(longint v);
        return 16'(round_away(v, 28, 1'b1));
    endfunction

    function automatic eatrm_pkg::out_beat_t rotation_of(eatrm_pkg::in_beat_t a);
        longint sx, cx, sy, cy, sz, cz;
        longint k;
        eatrm_pkg::out_beat_t o;
        k = 16384;
        angle_sincos(a.roll_angle, sx, cx);
        angle_sincos(a.pitch_angle, sy, cy);
        angle_sincos(a.yaw_angle, sz, cz);
        o.r00 = q42_elem(cy * cz * k);
        o.r01 = q42_elem(-(cy * sz * k));
        o.r02 = q42_elem(sy * k * k);
        o.r10 = q42_elem(sx * sy * cz + cx * sz * k);
        o.r11 = q42_elem(cx * cz * k - sx * sy * sz);
        o.r12 = q42_elem(-(sx * cy * k));
        o.r20 = q42_elem(sx * sz * k - cx * sy * cz);
        o.r21 = q42_elem(cx * sy * sz + sx * cz * k);
        o.r22 = q42_elem(cx * cy * k);
        return o;
    endfunction

    function automatic bit field_bad(string nm, logic signed [15:0] e, logic signed [15:0] g,
                                     int shown);
        if (e === g) return 1'b0;
        if (shown < 10)
            $display("mismatch %s: expected %0d got %0d", nm, e, g);
        return 1'b1;
    endfunction

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        eatrm_pkg::out_beat_t exp_m;
        bit bad;
        if (!aresetn) begin
            fail_count <= 0;
            pending_count <= 0;
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) matrix_queue.push_back(rotation_of(s_data));
            if (m_valid && m_ready) begin
                if (matrix_queue.size() == 0) begin
                    if (mismatch_count < 10) $display("unexpected result beat");
                    mismatch_count++;
                end else begin
                    exp_m = matrix_queue.pop_front();
                    bad = 0;
                    bad |= field_bad("r00", exp_m.r00, m_data.r00, mismatch_count);
                    bad |= field_bad("r01", exp_m.r01, m_data.r01, mismatch_count);
                    bad |= field_bad("r02", exp_m.r02, m_data.r02, mismatch_count);
                    bad |= field_bad("r10", exp_m.r10, m_data.r10, mismatch_count);
                    bad |= field_bad("r11", exp_m.r11, m_data.r11, mismatch_count);
                    bad |= field_bad("r12", exp_m.r12, m_data.r12, mismatch_count);
                    bad |= field_bad("r20", exp_m.r20, m_data.r20, mismatch_count);
                    bad |= field_bad("r21", exp_m.r21, m_data.r21, mismatch_count);
                    bad |= field_bad("r22", exp_m.r22, m_data.r22, mismatch_count);
                    if (bad) mismatch_count++;
                end
            end
            fail_count <= mismatch_count;
            pending_count <= matrix_queue.size();
        end
    end
endmodule

// ===== tb/euler_angles_to_rotation_matrix_core_tb.sv =====
module euler_angles_to_rotation_matrix_core_tb;
    localparam int CycleLimit = 200000;
    localparam int RandomBeats = 1150;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    eatrm_pkg::in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    eatrm_pkg::out_beat_t m_data;
    int        fail_count;
    int        pending_count;
    int        cycle_count = 0;
    bit        hold_req = 1'b0;
    logic signed [15:0] edge_angles[$];

    euler_angles_to_rotation_matrix_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    euler_angles_to_rotation_matrix_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // end the run at the cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one beat, after a random gap unless no_gap is set, and hold it until accepted
    task automatic send_beat(input eatrm_pkg::in_beat_t b, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // pace the sink: random waits, with one long hold-off
    initial begin
        int w;
        bit hold_done;
        hold_done = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_done = 1;
            end
            w = $urandom_range(0, 3);
            if (w == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        eatrm_pkg::in_beat_t b;
        int i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: range ends, zero and +/-1, pi/4, pi/2 and pi, beyond pi
        edge_angles = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                        16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736, 16'sd6434,
                        -16'sd6434, 16'sd25737, 16'sd30000};
        foreach (edge_angles[j]) begin
            b.roll_angle  = edge_angles[j];
            b.pitch_angle = edge_angles[(j + 3) % edge_angles.size()];
            b.yaw_angle   = edge_angles[(j + 7) % edge_angles.size()];
            send_beat(b, 1'b0);
        end
        b = '{16'sh8000, 16'sh8000, 16'sh8000}; send_beat(b, 1'b0);
        b = '{16'sh7fff, 16'sh7fff, 16'sh7fff}; send_beat(b, 1'b0);
        b = '{16'sd6434, 16'sd6434, 16'sd6434}; send_beat(b, 1'b0);

        // random part with a backpressure burst and a drain pause
        for (i = 0; i < RandomBeats; i++) begin
            if (i == 200) hold_req = 1;
            if (i == 600) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            b.roll_angle  = 16'($urandom);
            b.pitch_angle = 16'($urandom);
            b.yaw_angle   = 16'($urandom);
            send_beat(b, (i >= 200 && i < 260) || (i >= 800 && i < 900));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/eatrm_pkg.sv
design/eatrm_sincos.sv
design/eatrm_matrix.sv
design/euler_angles_to_rotation_matrix_core.sv
tb/euler_angles_to_rotation_matrix_checker.sv
tb/euler_angles_to_rotation_matrix_core_tb.sv
